// File: rtl/ami_pkg.sv
`default_nettype none
package ami_pkg;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_SINGULAR   = 2'd1,
    STATUS_NOT_AFFINE = 2'd2
  } status_e;

  // register index, taken from paddr[2]
  localparam logic REG_TOL = 1'b0;
  localparam logic REG_THR = 1'b1;

  // (x + 1) mod 3
  function automatic logic [1:0] nxt3(input logic [1:0] x);
    logic [1:0] r;
    unique case (x)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // row of cofactor index m = 3*row + col
  function automatic logic [1:0] m_row(input logic [3:0] m);
    logic [1:0] r;
    unique case (m)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // column of cofactor index
  function automatic logic [1:0] m_col(input logic [3:0] m);
    logic [1:0] r;
    unique case (m)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // cofactor index of row k, column 0
  function automatic logic [3:0] m_base(input logic [1:0] k);
    logic [3:0] r;
    unique case (k)
      2'd0:    r = 4'd0;
      2'd1:    r = 4'd3;
      default: r = 4'd6;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ami_mul.sv
`default_nettype none
module ami_mul #(
  parameter int W = 33
) (
  input  wire logic                  clk_i,
  input  wire logic signed [W-1:0]   a_i,
  input  wire logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0]      p_o
);

  // registered signed product
  logic signed [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// File: rtl/ami_div.sv
`default_nettype none
module ami_div #(
  parameter int NW = 96,
  parameter int DW = 96
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] den_q;

  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;
  logic          ge;

  // one restoring step: shift in next numerator bit, try subtract
  always_comb begin
    rem_sh = {rem_q, quo_q[NW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    ge     = ~diff[DW+1];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// File: rtl/affine_matrix4_inverse.sv
// channel  | dir | handshake              | payload
// s_axis   | in  | s_axis_tvalid/tready   | tdata: row, col, value; tlast: last element
// m_axis   | out | m_axis_tvalid/tready   | tdata: row, col, value; tuser: status;
//          |     |                        | tlast: sixteenth element
// apb      | in  | psel, penable, pwrite  | paddr[2] picks tolerance or threshold
//
// an element that is not last is stored and the port stays ready for the next
// a last element starts the sequencer: the affine check, the cofactors, the
// determinant and the threshold compare, then 9 divisions in the shared
// bit-serial divider and the translation on the shared multiplier; identity
// cases skip to output after the check or the threshold compare
// the 16 results leave one per cycle while m_axis_tready is high; s_axis is not
// ready from the last element until the sixteenth result transfer
// reset clears control and registers; the element store is not cleared
`default_nettype none
module affine_matrix4_inverse
  import ami_pkg::*;
#(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRAC_BITS     = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // element_row, element_col, element_value, zero fill
  input  wire logic [((ELEMENT_WIDTH+4+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic                                  s_axis_tlast,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // out_row, out_col, out_value, zero fill
  output logic [((ELEMENT_WIDTH+4+7)/8)*8-1:0]      m_axis_tdata,
  // status
  output logic [1:0]                                 m_axis_tuser,
  output logic                                       m_axis_tlast,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [2:0]                            paddr,
  input  wire logic [31:0]                           pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready
);

  localparam int E    = ELEMENT_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int TDW  = ((E + 4 + 7) / 8) * 8;
  localparam int MX   = E + 1;
  localparam int PW   = 2 * MX;
  localparam int ACW  = 3 * E + 4;
  localparam int MNW  = 2 * E + 1;
  localparam int NW   = 2 * E + 2 * F;
  localparam int DW   = 3 * E;
  localparam int MW   = (ACW > NW) ? ACW : NW;
  localparam int AW0  = (E > F + 2) ? E : F + 2;
  localparam int AW   = ((AW0 > 16) ? AW0 : 16) + 2;
  localparam int TW   = 16 + 2 * F;
  localparam int CW   = ((ACW > TW) ? ACW : TW) + 1;
  localparam logic [63:0]  ONE64   = 64'd1 << F;
  localparam logic [E-1:0] ONE_SAT = (F < E - 1) ? ONE64[E-1:0] : {1'b0, {(E-1){1'b1}}};
  localparam logic [MW-1:0] LIM    = MW'(1) << (E - 1);

  typedef enum logic [2:0] {
    S_LOAD, S_AFF, S_MIN, S_DET, S_THR, S_DIV, S_TRN, S_OUT
  } state_e;

  state_e  state_q;
  logic [3:0] cnt_q;
  logic [2:0] ph_q;
  logic [1:0] k_q;
  logic       aff_bad_q;
  status_e    status_q;
  logic [15:0] tol_q;
  logic [15:0] thr_q;

  logic [E-1:0]            store_q [16];
  logic signed [MX-1:0]    opa_q;
  logic signed [ACW-1:0]   acc_q;
  logic signed [MNW-1:0]   num_q [9];
  logic [E-1:0]            res_q [16];

  logic                    in_xfer;
  logic                    out_xfer;
  logic [3:0]              rd_addr;
  logic signed [MX-1:0]    elem_x;
  logic [3:0]              num_idx;
  logic signed [MNW-1:0]   num_rd;
  logic [3:0]              res_idx;
  logic [E-1:0]            res_rd;
  logic signed [MX-1:0]    mul_a;
  logic signed [MX-1:0]    mul_b;
  logic signed [PW-1:0]    mul_p;
  logic signed [ACW-1:0]   p_ext;
  logic [ACW-1:0]          acc_abs;
  logic [MNW-1:0]          num_abs;
  logic                    div_start;
  logic                    div_done;
  logic [NW-1:0]           div_quo;
  logic                    sat_neg;
  logic [MW-1:0]           sat_mag;
  logic [MW-1:0]           sat_c;
  logic [E-1:0]            sat_val;
  logic signed [AW-1:0]    aff_d;
  logic [AW-1:0]           aff_abs;
  logic                    aff_hit;
  logic                    singular;
  logic [1:0]              mi;
  logic [1:0]              mj;
  logic [1:0]              mi1;
  logic [1:0]              mi2;
  logic [1:0]              mj1;
  logic [1:0]              mj2;
  logic [1:0]              o_row;
  logic [1:0]              o_col;
  logic [E-1:0]            o_val;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_xfer = m_axis_tvalid & m_axis_tready;

  // cofactor index decode
  always_comb begin
    mi  = m_row(cnt_q);
    mj  = m_col(cnt_q);
    mi1 = nxt3(mi);
    mi2 = nxt3(mi1);
    mj1 = nxt3(mj);
    mj2 = nxt3(mj1);
  end

  // store read address per step
  always_comb begin
    rd_addr = '0;
    unique case (state_q)
      S_AFF: rd_addr = {cnt_q[1:0], 2'd3};
      S_MIN: begin
        unique case (ph_q)
          3'd0:    rd_addr = {mj1, mi1};
          3'd1:    rd_addr = {mj2, mi2};
          3'd2:    rd_addr = {mj1, mi2};
          default: rd_addr = {mj2, mi1};
        endcase
      end
      S_DET:   rd_addr = {2'd0, cnt_q[1:0]};
      S_TRN:   rd_addr = {2'd3, k_q};
      default: rd_addr = '0;
    endcase
  end

  assign elem_x  = MX'($signed(store_q[rd_addr]));
  assign num_idx = (state_q == S_DIV) ? cnt_q : m_base(cnt_q[1:0]);
  assign num_rd  = num_q[num_idx];
  assign res_idx = (state_q == S_OUT) ? cnt_q : {k_q, cnt_q[1:0]};
  assign res_rd  = res_q[res_idx];

  // shared multiplier operands
  always_comb begin
    mul_a = elem_x;
    mul_b = MX'($signed(res_rd));
    unique case (state_q)
      S_MIN: begin
        mul_a = opa_q;
        mul_b = elem_x;
      end
      S_DET: mul_b = (ph_q == 3'd0) ? $signed({1'b0, num_rd[E-1:0]}) : num_rd[MNW-1:E];
      default: mul_b = MX'($signed(res_rd));
    endcase
  end

  ami_mul #(.W(MX)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign p_ext   = ACW'(mul_p);
  assign acc_abs = acc_q[ACW-1] ? ACW'(-acc_q) : ACW'(acc_q);
  assign num_abs = num_rd[MNW-1] ? MNW'(-num_rd) : MNW'(num_rd);

  // divisions of shifted cofactor by determinant
  assign div_start = (state_q == S_DIV) && (ph_q == 3'd0);

  ami_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({num_abs[2*E-1:0], {(2*F){1'b0}}}),
    .den_i   (acc_abs[DW-1:0]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // saturation to the element range
  always_comb begin
    if (state_q == S_DIV) begin
      sat_neg = num_rd[MNW-1] ^ acc_q[ACW-1];
      sat_mag = MW'(div_quo);
    end else begin
      sat_neg = ~acc_q[ACW-1];
      sat_mag = MW'(acc_abs >> F);
    end
    if (sat_neg) begin
      sat_c   = (sat_mag > LIM) ? LIM : sat_mag;
      sat_val = E'(-sat_c);
    end else begin
      sat_c   = (sat_mag > LIM - 1'b1) ? LIM - 1'b1 : sat_mag;
      sat_val = sat_c[E-1:0];
    end
  end

  // affine column check and singular check
  always_comb begin
    aff_d   = AW'($signed(store_q[rd_addr])) - ((cnt_q[1:0] == 2'd3) ? AW'(ONE64) : AW'(0));
    aff_abs = aff_d[AW-1] ? AW'(-aff_d) : AW'(aff_d);
    aff_hit = aff_abs > AW'(tol_q);
    singular = CW'(acc_abs) <= CW'({thr_q, {(2*F){1'b0}}});
  end

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      cnt_q     <= '0;
      ph_q      <= '0;
      k_q       <= '0;
      aff_bad_q <= 1'b0;
      status_q  <= STATUS_OK;
      tol_q     <= 16'd66;
      thr_q     <= 16'd0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_TOL) tol_q <= pwdata[15:0];
        else                     thr_q <= pwdata[15:0];
      end
      unique case (state_q)
        S_LOAD: begin
          if (in_xfer && s_axis_tlast) begin
            state_q   <= S_AFF;
            cnt_q     <= '0;
            aff_bad_q <= 1'b0;
          end
        end
        S_AFF: begin
          aff_bad_q <= aff_bad_q | aff_hit;
          cnt_q     <= cnt_q + 1'b1;
          if (cnt_q[1:0] == 2'd3) begin
            cnt_q <= '0;
            ph_q  <= '0;
            if (aff_bad_q || aff_hit) begin
              status_q <= STATUS_NOT_AFFINE;
              state_q  <= S_OUT;
            end else begin
              status_q <= STATUS_OK;
              state_q  <= S_MIN;
            end
          end
        end
        S_MIN: begin
          ph_q <= ph_q + 1'b1;
          if (ph_q == 3'd4) begin
            ph_q  <= '0;
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == 4'd8) begin
              cnt_q   <= '0;
              state_q <= S_DET;
            end
          end
        end
        S_DET: begin
          ph_q <= ph_q + 1'b1;
          if (ph_q == 3'd2) begin
            ph_q  <= '0;
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == 4'd2) begin
              cnt_q   <= '0;
              state_q <= S_THR;
            end
          end
        end
        S_THR: begin
          cnt_q <= '0;
          ph_q  <= '0;
          if (singular) begin
            status_q <= STATUS_SINGULAR;
            state_q  <= S_OUT;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (ph_q == 3'd0) begin
            ph_q <= 3'd1;
          end else if (div_done) begin
            ph_q  <= '0;
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == 4'd8) begin
              cnt_q   <= '0;
              k_q     <= '0;
              state_q <= S_TRN;
            end
          end
        end
        S_TRN: begin
          unique case (ph_q)
            3'd0: ph_q <= 3'd1;
            3'd1: begin
              if (k_q == 2'd2) begin
                ph_q <= 3'd2;
              end else begin
                k_q  <= k_q + 1'b1;
                ph_q <= '0;
              end
            end
            default: begin
              ph_q  <= '0;
              k_q   <= '0;
              cnt_q <= cnt_q + 1'b1;
              if (cnt_q == 4'd2) begin
                cnt_q   <= '0;
                state_q <= S_OUT;
              end
            end
          endcase
        end
        S_OUT: begin
          if (out_xfer) begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == 4'd15) begin
              cnt_q   <= '0;
              state_q <= S_LOAD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // element store, indexed by row then column
  always_ff @(posedge clk_i) begin
    if (in_xfer) store_q[{s_axis_tdata[1:0], s_axis_tdata[3:2]}] <= s_axis_tdata[E+3:4];
  end

  // accumulator, operand latch, cofactors and results
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_MIN: begin
        if (ph_q == 3'd0 || ph_q == 3'd2) opa_q <= elem_x;
        if (ph_q == 3'd2) acc_q <= p_ext;
        if (ph_q == 3'd4) begin
          num_q[cnt_q] <= MNW'(acc_q - p_ext);
          acc_q        <= '0;
        end
      end
      S_DET: begin
        if (ph_q == 3'd1) acc_q <= acc_q + p_ext;
        if (ph_q == 3'd2) acc_q <= acc_q + (p_ext <<< E);
      end
      S_DIV: begin
        if (ph_q != 3'd0 && div_done) res_q[{mi, mj}] <= sat_val;
        if (ph_q != 3'd0 && div_done && cnt_q == 4'd8) acc_q <= '0;
      end
      S_TRN: begin
        if (ph_q == 3'd1) acc_q <= acc_q + p_ext;
        if (ph_q == 3'd2) begin
          res_q[{2'd3, cnt_q[1:0]}] <= sat_val;
          acc_q                     <= '0;
        end
      end
      default: begin
        if (state_q == S_AFF) acc_q <= '0;
      end
    endcase
  end

  // result element selection
  always_comb begin
    o_row = cnt_q[3:2];
    o_col = cnt_q[1:0];
    if (status_q != STATUS_OK || o_col == 2'd3) o_val = (o_row == o_col) ? ONE_SAT : '0;
    else                                         o_val = res_rd;
  end

  assign s_axis_tready = (state_q == S_LOAD);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = TDW'({o_val, o_col, o_row});
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = (cnt_q == 4'd15);

  // register read
  assign prdata = (paddr[2] == REG_TOL) ? {16'd0, tol_q} : {16'd0, thr_q};
  assign pready = 1'b1;

endmodule
`default_nettype wire
